// File: rtl/tdw_pkg.sv
`timescale 1ns / 1ps

package tdw_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned TokW   = 32;
  localparam int unsigned OpW    = 3;

  localparam logic [OpW-1:0] OpArm      = 3'd0;
  localparam logic [OpW-1:0] OpTryFire  = 3'd1;
  localparam logic [OpW-1:0] OpComplete = 3'd2;
  localparam logic [OpW-1:0] OpQuery    = 3'd3;
  localparam logic [OpW-1:0] OpTick     = 3'd4;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TimeW-1:0] now_ns;
    logic [TimeW-1:0] runtime_deadline_ns;
    logic [TimeW-1:0] svc_window_ns;
    logic [TokW-1:0]  token_in;
  } req_t;

  typedef struct packed {
    logic [TokW-1:0] token_out;
    logic            flag;
  } rsp_t;

  typedef struct packed {
    logic             fired;
    logic [TimeW-1:0] runtime_limit;
    logic [TimeW-1:0] service_limit;
  } slot_t;

endpackage

// File: rtl/tdw_exec.sv
`timescale 1ns / 1ps

module tdw_exec import tdw_pkg::*; #(
  parameter int unsigned TOKEN_BITS = 32
) (
  input  logic                  enable_i,
  input  req_t                  req_i,
  input  logic [TOKEN_BITS-1:0] last_token_i,
  input  logic [TOKEN_BITS-1:0] armed_token_i,
  input  slot_t                 slot_i,
  output logic [TOKEN_BITS-1:0] last_token_o,
  output logic [TOKEN_BITS-1:0] armed_token_o,
  output slot_t                 slot_o,
  output rsp_t                  rsp_o
);

  localparam int unsigned CmpW = (TOKEN_BITS > TokW) ? TOKEN_BITS : TokW;

  logic [TOKEN_BITS-1:0] armed_eff;
  logic                  fired_eff;
  logic                  match;
  logic                  rt_reached;
  logic                  svc_reached;
  logic [TimeW:0]        sum;
  logic [TimeW-1:0]      svc_sat;
  logic [TOKEN_BITS-1:0] tok_inc;
  logic [TOKEN_BITS-1:0] tok_new;
  logic [CmpW-1:0]       tok_new_ext;

  assign armed_eff   = enable_i ? armed_token_i : '0;
  assign fired_eff   = enable_i & slot_i.fired;
  assign match       = (req_i.token_in != '0) && (armed_eff != '0) &&
                       (CmpW'(armed_eff) == CmpW'(req_i.token_in));
  assign rt_reached  = req_i.now_ns >= slot_i.runtime_limit;
  assign svc_reached = req_i.now_ns >= slot_i.service_limit;
  assign sum         = {1'b0, req_i.now_ns} + {1'b0, req_i.svc_window_ns};
  assign svc_sat     = sum[TimeW] ? '1 : sum[TimeW-1:0];
  assign tok_inc     = last_token_i + TOKEN_BITS'(1);
  assign tok_new     = (tok_inc == '0) ? TOKEN_BITS'(1) : tok_inc;
  assign tok_new_ext = CmpW'(tok_new);

  always_comb begin
    last_token_o  = last_token_i;
    armed_token_o = armed_eff;
    slot_o        = slot_i;
    slot_o.fired  = fired_eff;
    rsp_o         = '0;
    unique case (req_i.op)
      OpArm: begin
        if (enable_i) begin
          last_token_o         = tok_new;
          armed_token_o        = tok_new;
          slot_o.fired         = 1'b0;
          slot_o.runtime_limit = req_i.runtime_deadline_ns;
          slot_o.service_limit = svc_sat;
          rsp_o.token_out      = tok_new_ext[TokW-1:0];
        end
      end
      OpTryFire: begin
        if (match && rt_reached && !fired_eff) begin
          slot_o.fired = 1'b1;
          rsp_o.flag   = 1'b1;
        end
      end
      OpComplete: begin
        if (match) begin
          rsp_o.flag    = fired_eff | rt_reached;
          armed_token_o = '0;
          slot_o.fired  = 1'b0;
        end
      end
      OpQuery: begin
        rsp_o.flag = match & fired_eff;
      end
      OpTick: begin
        if ((armed_eff != '0) && !fired_eff && svc_reached) begin
          slot_o.fired = 1'b1;
          rsp_o.flag   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/tdw_slot.sv
`timescale 1ns / 1ps

module tdw_slot import tdw_pkg::*; #(
  parameter int unsigned TOKEN_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  step_i,
  input  logic [TOKEN_BITS-1:0] last_token_d_i,
  input  logic [TOKEN_BITS-1:0] armed_token_d_i,
  input  slot_t                 slot_d_i,
  output logic                  enable_o,
  output logic [TOKEN_BITS-1:0] last_token_o,
  output logic [TOKEN_BITS-1:0] armed_token_o,
  output slot_t                 slot_o
);

  logic                  enable_q;
  logic [TOKEN_BITS-1:0] last_token_q;
  logic [TOKEN_BITS-1:0] armed_token_q;
  slot_t                 slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      last_token_q  <= '0;
      armed_token_q <= '0;
      slot_q        <= '0;
    end else if (cfg_we_i) begin
      if (!cfg_wdata_i || !enable_q) begin
        armed_token_q <= '0;
        slot_q.fired  <= 1'b0;
      end
      enable_q <= cfg_wdata_i;
    end else if (step_i) begin
      last_token_q  <= last_token_d_i;
      armed_token_q <= armed_token_d_i;
      slot_q        <= slot_d_i;
    end
  end

  assign enable_o      = enable_q;
  assign last_token_o  = last_token_q;
  assign armed_token_o = armed_token_q;
  assign slot_o        = slot_q;

endmodule

// File: rtl/token_deadline_watchdog.sv
`timescale 1ns / 1ps

// Single-slot deadline watchdog with tokens.
// Request channel: in_valid_i / in_stall_o with op, now, deadlines and token.
// Response channel: out_valid_o / out_stall_i with token_out_o and flag_o.
// Every request yields exactly one response, in order.
// Ops: arm issues a token, try-fire, complete, query fired, service tick.
// The input register takes an accepted request, and its response is then
// registered in the response register, which drives out_valid_o.
// Throughput is one request per cycle while the receiver does not stall; the
// slot state is updated at the same edge that registers the response.
// When the receiver stalls, the response register holds and the input
// register holds one more request; in_stall_o then rises.
// Reset clears enable, the tokens, the slot and both valid bits.
// The user must write enable (cfg_we_i, cfg_wdata_i) while the block is idle;
// not enforced. Writing 0 or switching 0 to 1 clears armed token and fired bit.

module token_deadline_watchdog import tdw_pkg::*; #(
  parameter int unsigned TOKEN_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OpW-1:0]         op_i,
  input  logic [TimeW-1:0]       now_ns_i,
  input  logic [TimeW-1:0]       runtime_deadline_ns_i,
  input  logic [TimeW-1:0]       svc_window_ns_i,
  input  logic [TokW-1:0]        token_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [TokW-1:0]        token_out_o,
  output logic                   flag_o
);

  logic                  req_valid_q;
  req_t                  req_q;
  logic                  rsp_valid_q;
  rsp_t                  rsp_q;
  rsp_t                  rsp_d;
  logic                  advance;
  logic                  accept;
  logic                  enable;
  logic [TOKEN_BITS-1:0] last_token;
  logic [TOKEN_BITS-1:0] armed_token;
  slot_t                 slot;
  logic [TOKEN_BITS-1:0] last_token_d;
  logic [TOKEN_BITS-1:0] armed_token_d;
  slot_t                 slot_d;

  assign advance    = !rsp_valid_q || !out_stall_i;
  assign in_stall_o = req_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!req_valid_q || advance) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.op                  <= op_i;
      req_q.now_ns              <= now_ns_i;
      req_q.runtime_deadline_ns <= runtime_deadline_ns_i;
      req_q.svc_window_ns       <= svc_window_ns_i;
      req_q.token_in            <= token_in_i;
    end
  end

  tdw_exec #(
    .TOKEN_BITS(TOKEN_BITS)
  ) u_exec (
    .enable_i      (enable),
    .req_i         (req_q),
    .last_token_i  (last_token),
    .armed_token_i (armed_token),
    .slot_i        (slot),
    .last_token_o  (last_token_d),
    .armed_token_o (armed_token_d),
    .slot_o        (slot_d),
    .rsp_o         (rsp_d)
  );

  tdw_slot #(
    .TOKEN_BITS(TOKEN_BITS)
  ) u_slot (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .step_i          (req_valid_q && advance),
    .last_token_d_i  (last_token_d),
    .armed_token_d_i (armed_token_d),
    .slot_d_i        (slot_d),
    .enable_o        (enable),
    .last_token_o    (last_token),
    .armed_token_o   (armed_token),
    .slot_o          (slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign token_out_o = rsp_q.token_out;
  assign flag_o      = rsp_q.flag;

endmodule
